@@ rtl/ring_buffer_deque_with_search_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ring buffer deque
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_WITH_SEARCH_ASSERT_SVH
`define RING_BUFFER_DEQUE_WITH_SEARCH_ASSERT_SVH

// same-cycle implication
`define RBDQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rbdq assertion failed");

// next-cycle implication
`define RBDQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rbdq assertion failed");

`endif

@@ rtl/rbdq_pkg.sv @@
// ----------------------------------------------------------------------------
// rbdq_pkg
// Types and constants shared by the ring buffer deque modules.
// ----------------------------------------------------------------------------
package rbdq_pkg;

   localparam int VALUE_W  = 16;
   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int RSP_W    = 32;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_POP,
      S_SEARCH,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic push;
      logic clear;
      logic set_under;
      logic set_over;
      logic pop_issue;
      logic pop_done;
      logic search_start;
      logic search_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   hit;
      logic   last;
      logic   rsp_free;
   } stat_type;

endpackage

@@ rtl/rbdq_ram.sv @@
// ----------------------------------------------------------------------------
// rbdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbdq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rbdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbdq_ctrl
// Sequencer for the deque: decodes each request and steps the datapath.
// ----------------------------------------------------------------------------
module rbdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rbdq_pkg::stat_type stat,
   output rbdq_pkg::cmd_type  cmd
);
   import rbdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESULT;
            unique case (stat.op)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.set_over = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.set_under = 1'b1;
                  end else begin
                     cmd.pop_issue = 1'b1;
                     state_in      = S_POP;
                  end
               end
               OP_SEARCH: begin
                  if (!stat.empty) begin
                     cmd.search_start = 1'b1;
                     state_in         = S_SEARCH;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_POP: begin
            cmd.pop_done = 1'b1;
            state_in     = S_RESULT;
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (stat.hit || stat.last) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/rbdq_dp.sv @@
// ----------------------------------------------------------------------------
// rbdq_dp
// Deque datapath: pointers, fill count, search scan and the result register.
// ----------------------------------------------------------------------------
module rbdq_dp #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rbdq_pkg::OP_W-1:0]     req_op,
   input  logic [rbdq_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rbdq_pkg::RSP_W-1:0]    rsp_tdata,
   input  rbdq_pkg::cmd_type             cmd_i,
   output rbdq_pkg::stat_type            stat
);
   import rbdq_pkg::*;

`include "ring_buffer_deque_with_search_assert.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] p);
      return (p == '0) ? LAST : p - AW'(1);
   endfunction

   op_type                op_ff, op_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [AW-1:0]         front_ff, front_in;
   logic [AW-1:0]         back_ff, back_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [AW-1:0]         scan_ff, scan_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] res_data_ff, res_data_in;
   logic                  res_found_ff, res_found_in;
   logic [AW-1:0]         res_pos_ff, res_pos_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  hit;

   rbdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit = (rd_data == value_ff);

   always_comb begin
      stat.op       = op_ff;
      stat.empty    = (fill_ff == '0);
      stat.full     = (fill_ff == FW'(DEPTH));
      stat.hit      = hit;
      stat.last     = ((FW'(pos_ff) + FW'(1)) == fill_ff);
      stat.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      op_in         = op_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      fill_in       = fill_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      res_data_in   = res_data_ff;
      res_found_in  = res_found_ff;
      res_pos_in    = res_pos_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      rd_en         = 1'b0;
      rd_addr       = scan_ff;

      if (cmd_i.capture) begin
         op_in         = op_type'(req_op);
         value_in      = DATA_WIDTH'(req_value);
         res_data_in   = '0;
         res_found_in  = 1'b0;
         res_pos_in    = '0;
         res_status_in = ST_OK;
      end

      if (cmd_i.push) begin
         wr_en   = 1'b1;
         fill_in = fill_ff + FW'(1);
         if (fill_ff == '0) begin
            front_in = '0;
            back_in  = '0;
            wr_addr  = '0;
         end else if (op_ff == OP_PUSH_FRONT) begin
            front_in = prev_idx(front_ff);
            wr_addr  = prev_idx(front_ff);
         end else begin
            back_in = next_idx(back_ff);
            wr_addr = next_idx(back_ff);
         end
      end

      if (cmd_i.set_under) begin
         res_status_in = ST_UNDERFLOW;
      end
      if (cmd_i.set_over) begin
         res_status_in = ST_OVERFLOW;
      end

      if (cmd_i.clear) begin
         front_in = '0;
         back_in  = '0;
         fill_in  = '0;
      end

      if (cmd_i.pop_issue) begin
         rd_en   = 1'b1;
         rd_addr = (op_ff == OP_POP_FRONT) ? front_ff : back_ff;
      end

      if (cmd_i.pop_done) begin
         res_data_in = rd_data;
         fill_in     = fill_ff - FW'(1);
         if (op_ff == OP_POP_FRONT) begin
            front_in = next_idx(front_ff);
         end else begin
            back_in = prev_idx(back_ff);
         end
      end

      // scan keeps one read in flight: rd_data holds entry pos_ff from the front
      if (cmd_i.search_start) begin
         rd_en   = 1'b1;
         rd_addr = front_ff;
         scan_in = next_idx(front_ff);
         pos_in  = '0;
      end

      if (cmd_i.search_step) begin
         rd_en   = 1'b1;
         rd_addr = scan_ff;
         scan_in = next_idx(scan_ff);
         pos_in  = pos_ff + AW'(1);
         if (hit) begin
            res_found_in = 1'b1;
            res_pos_in   = pos_ff;
         end
      end

      if (cmd_i.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {COUNT_W'(fill_ff), res_status_ff, POS_W'(res_pos_ff),
                         res_found_ff, VALUE_W'(res_data_ff)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      res_data_ff   <= res_data_in;
      res_found_ff  <= res_found_in;
      res_pos_ff    <= res_pos_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RBDQ_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= FW'(DEPTH))
   `RBDQ_ASSERT_NEXT(a_push_fill, cmd_i.push, fill_ff == $past(fill_ff) + FW'(1))
   `RBDQ_ASSERT_IMPL(a_hit_in_range, cmd_i.search_step && hit, FW'(pos_ff) < fill_ff)
   `RBDQ_ASSERT_IMPL(a_no_overwrite, cmd_i.load_rsp, !rsp_valid_ff || rsp_tready)

endmodule

@@ rtl/ring_buffer_deque_with_search.sv @@
// ----------------------------------------------------------------------------
// ring_buffer_deque_with_search
// Double-ended queue in a circular RAM with push, pop, search and clear.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat is one request; tuser carries the op code, tdata
//   the value to push or to search for.
//   rsp channel: one beat per request with popped data, search result,
//   status (underflow/overflow) and the element count after the request.
//   After a request is accepted, push, clear, no-op, a pop of an empty
//   queue and a search of an empty queue pass the decode and result
//   states; any other pop also passes the pop state, and any other search
//   scans 1 .. DEPTH entries in the search state, stopping at a hit or at
//   the last entry, with one RAM read per entry.
//   One request is in work at a time; req_tready rises again the cycle
//   after its result is loaded into the output register.
//   The output register holds a beat while rsp_tready is low; the next
//   request is still accepted and waits in its result state.
//   Reset empties the queue at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module ring_buffer_deque_with_search #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rbdq_pkg::VALUE_W-1:0] req_tdata,   // value
   input  logic [rbdq_pkg::OP_W-1:0]    req_tuser,   // op
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [rbdq_pkg::RSP_W-1:0]   rsp_tdata    // data, found, position, status, count
);
   import rbdq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rbdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rbdq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_value  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd_i      (cmd),
      .stat       (stat)
   );

endmodule
